/* src/lmfs_pkg.sv */
// Shared constants, types and the brightness curve of the LED matrix fade scanner.
package lmfs_pkg;

	// Field widths fixed by the interface.
	localparam int TGT_W    = 8;
	localparam int COL_F_W  = 3;
	localparam int ROW_F_W  = 3;
	localparam int LEVEL_W  = 8;

	// Geometry defaults and the widest row or column index the geometry allows.
	localparam int COLUMNS_DEF = 8;
	localparam int ROWS_DEF    = 8;
	localparam int IDX_W       = 4;

	// Fade counter.
	localparam int                 CNT_W = 6;
	localparam int                 STEPS = 64;
	localparam logic [CNT_W-1:0]   TOP   = CNT_W'(STEPS - 1);

	localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;

	// Configuration port.
	localparam int   PADDR_W = 3;
	localparam int   PDATA_W = 32;
	localparam logic REG_FADE_STEP = 1'b0;

	// Perceptual brightness curve, indexed by the fade counter.
	localparam logic [LEVEL_W-1:0] CURVE [0:63] = '{
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,
		8'd2,   8'd3,   8'd3,   8'd4,   8'd4,   8'd5,   8'd5,   8'd6,
		8'd6,   8'd7,   8'd8,   8'd9,   8'd10,  8'd11,  8'd12,  8'd13,
		8'd14,  8'd16,  8'd17,  8'd19,  8'd21,  8'd23,  8'd25,  8'd28,
		8'd30,  8'd33,  8'd36,  8'd40,  8'd44,  8'd48,  8'd52,  8'd57,
		8'd62,  8'd68,  8'd74,  8'd81,  8'd89,  8'd97,  8'd106, 8'd115,
		8'd126, 8'd138, 8'd150, 8'd164, 8'd179, 8'd195, 8'd213, 8'd255
	};

	// One row lookup handed from the row sequencer to the fade stage.
	typedef struct packed {
		logic             valid;
		logic             on;
		logic             last;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} rd_req_t;

	// Sequencer status, watched at the top level.
	typedef struct packed {
		logic             busy;
		logic [IDX_W-1:0] row;
	} seq_stat_t;

endpackage

/* src/lmfs_scan_if.sv */
// Request channel carrying the row targets of one scan tick.
interface lmfs_scan_if;
	logic                        valid;
	logic                        ready;
	logic [lmfs_pkg::TGT_W-1:0]  row_targets;

	modport source (output valid, output row_targets, input ready);
	modport sink   (input valid, input row_targets, output ready);
endinterface

/* src/lmfs_drive_if.sv */
// Request channel carrying one row drive level.
interface lmfs_drive_if;
	logic                          valid;
	logic                          ready;
	logic [lmfs_pkg::COL_F_W-1:0]  column;
	logic [lmfs_pkg::ROW_F_W-1:0]  row;
	logic [lmfs_pkg::LEVEL_W-1:0]  level;
	logic                          last;

	modport source (output valid, output column, output row, output level, output last,
		input ready);
	modport sink   (input valid, input column, input row, input level, input last,
		output ready);
endinterface

/* src/lmfs_cfg.sv */
// APB register block holding the fade step.
module lmfs_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lmfs_pkg::PADDR_W-1:0]  paddr,
	input  logic [lmfs_pkg::PDATA_W-1:0]  pwdata,
	output logic [lmfs_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output logic [lmfs_pkg::CNT_W-1:0]    fade_step,
	output logic                          clear
);
	import lmfs_pkg::*;

	logic             reg_idx;
	logic             wr;
	logic [CNT_W-1:0] step_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1];
	assign wr      = psel && penable && pwrite && pready;
	// Writing the step also wipes every fade counter.
	assign clear   = wr && (reg_idx == REG_FADE_STEP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (clear) begin
			step_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata    = (reg_idx == REG_FADE_STEP) ? PDATA_W'(step_q) : '0;
	assign fade_step = step_q;

endmodule

/* src/lmfs_seq.sv */
// Row sequencer: holds one scan tick and issues one row lookup per cycle while the fade stage is ready.
module lmfs_seq #(
	parameter int COLUMNS = lmfs_pkg::COLUMNS_DEF,
	parameter int ROWS    = lmfs_pkg::ROWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	lmfs_scan_if.sink            scan,
	input  logic                 s1_ready,
	output lmfs_pkg::rd_req_t    rd_req,
	output lmfs_pkg::seq_stat_t  stat
);
	import lmfs_pkg::*;

	localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic             busy_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] act_col_q;
	logic [COL_W-1:0] col_q;
	logic [TGT_W-1:0] tgt_q;
	logic             issue;
	logic             last_row;
	logic             accept;

	assign issue    = busy_q && s1_ready;
	assign last_row = (row_q == ROW_W'(ROWS - 1));
	// A new tick is taken in the cycle the last row of the current one leaves.
	assign scan.ready = !busy_q || (issue && last_row);
	assign accept     = scan.valid && scan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			row_q     <= '0;
			act_col_q <= '0;
		end else if (accept) begin
			busy_q    <= 1'b1;
			row_q     <= '0;
			act_col_q <= (act_col_q == COL_W'(COLUMNS - 1)) ? '0 : act_col_q + 1'b1;
		end else if (issue && last_row) begin
			busy_q <= 1'b0;
		end else if (issue) begin
			row_q <= row_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_q <= scan.row_targets;
			col_q <= act_col_q;
		end
	end

	always_comb begin
		rd_req.valid = issue;
		// Rows past the width of the target field are always off.
		rd_req.on    = (32'(row_q) < TGT_W) && tgt_q[3'(row_q)];
		rd_req.last  = last_row;
		rd_req.row   = IDX_W'(row_q);
		rd_req.col   = IDX_W'(col_q);
		stat.busy    = busy_q;
		stat.row     = IDX_W'(row_q);
	end

endmodule

/* src/lmfs_fade.sv */
// Fade counter memory, level lookup, counter update and result register.
module lmfs_fade #(
	parameter int COLUMNS = lmfs_pkg::COLUMNS_DEF,
	parameter int ROWS    = lmfs_pkg::ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clear,
	input  logic [lmfs_pkg::CNT_W-1:0]  fade_step,
	input  lmfs_pkg::rd_req_t           rd_req,
	output logic                        s1_ready,
	lmfs_drive_if.source                drive
);
	import lmfs_pkg::*;

	localparam int DEPTH  = COLUMNS * ROWS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CNT_W-1:0]  mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;

	logic [ADDR_W-1:0] raddr;

	// Lookup stage.
	logic              valid_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              on_s1;
	logic              last_s1;
	logic [IDX_W-1:0]  row_s1;
	logic [IDX_W-1:0]  col_s1;
	logic [CNT_W-1:0]  mem_rd_s1;
	logic              hit_s1;
	logic              fwd_s1;
	logic [CNT_W-1:0]  fwd_cnt_s1;

	// Result stage.
	logic                valid_s2;
	logic [COL_F_W-1:0]  col_s2;
	logic [ROW_F_W-1:0]  row_s2;
	logic [LEVEL_W-1:0]  level_s2;
	logic                last_s2;

	logic               adv_s2;
	logic               wr_en;
	logic [CNT_W-1:0]   cnt;
	logic [CNT_W-1:0]   goal;
	logic [CNT_W:0]     sum;
	logic [CNT_W-1:0]   new_cnt;
	logic [LEVEL_W-1:0] level;

	assign adv_s2   = !valid_s2 || drive.ready;
	assign s1_ready = !valid_s1 || adv_s2;
	assign wr_en    = valid_s1 && adv_s2;
	assign raddr    = ADDR_W'(rd_req.col) + ADDR_W'(32'(rd_req.row) * COLUMNS);

	always_comb begin
		// Never-written entries read as zero; a write landing on the address
		// being read in the same cycle is forwarded.
		if (fwd_s1) begin
			cnt = fwd_cnt_s1;
		end else if (hit_s1) begin
			cnt = mem_rd_s1;
		end else begin
			cnt = '0;
		end
		if (cnt > TOP) begin
			cnt = TOP;
		end
		goal    = on_s1 ? TOP : '0;
		sum     = {1'b0, cnt} + {1'b0, fade_step};
		new_cnt = cnt;
		level   = CURVE[cnt];
		if ((fade_step == '0) && on_s1) begin
			level = LEVEL_FULL;
		end else if (cnt < goal) begin
			new_cnt = (sum > {1'b0, goal}) ? goal : sum[CNT_W-1:0];
		end else if (cnt > goal) begin
			new_cnt = (cnt > fade_step) ? cnt - fade_step : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_s1] <= new_cnt;
		end
		if (s1_ready) begin
			mem_rd_s1  <= mem[raddr];
			hit_s1     <= vld_q[raddr];
			fwd_s1     <= wr_en && (addr_s1 == raddr);
			fwd_cnt_s1 <= new_cnt;
			addr_s1    <= raddr;
			on_s1      <= rd_req.on;
			last_s1    <= rd_req.last;
			row_s1     <= rd_req.row;
			col_s1     <= rd_req.col;
		end
		if (adv_s2) begin
			col_s2   <= COL_F_W'(col_s1);
			row_s2   <= ROW_F_W'(row_s1);
			level_s2 <= level;
			last_s2  <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (clear) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[addr_s1] <= 1'b1;
			end
			if (s1_ready) begin
				valid_s1 <= rd_req.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign drive.valid  = valid_s2;
	assign drive.column = col_s2;
	assign drive.row    = row_s2;
	assign drive.level  = level_s2;
	assign drive.last   = last_s2;

endmodule

/* src/led_matrix_fade_scanner_top.sv */
// Top level of the LED matrix column scanner with per-LED fading.
// Each request on scan carries the on/off targets of every row in the active column; the
// block answers with ROWS requests on drive, one per row in row order, the final one
// flagged by last, and then moves on to the next column, wrapping after COLUMNS. Results
// leave at one per clock while drive is ready, and the next tick is taken in the same
// cycle as its predecessor's last row lookup, so ticks follow each other with no gap. The
// rate is set by the single drive port and the one-lookup-per-cycle port of the fade
// counter memory. The first row of a tick reaches drive through the row sequencer, which
// the accepting edge loads, then the registered counter read and the result register.
// Every LED owns a six-bit fade counter; the level it shows comes from a perceptual curve
// at the counter value from before the tick, and the counter then steps by fade_step
// toward full or off, clamping at either end. With fade_step at zero an LED that is on is
// driven at full brightness. Writing fade_step (register 0, byte address 0 of the APB
// port) clears every counter at once through per-entry valid flags, so there is no
// clearing pass; registers should only be written while no tick is in flight.
module led_matrix_fade_scanner_top #(
	parameter int COLUMNS = lmfs_pkg::COLUMNS_DEF,
	parameter int ROWS    = lmfs_pkg::ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	lmfs_scan_if.sink                     scan,
	lmfs_drive_if.source                  drive,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lmfs_pkg::PADDR_W-1:0]  paddr,
	input  logic [lmfs_pkg::PDATA_W-1:0]  pwdata,
	output logic [lmfs_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import lmfs_pkg::*;

	logic             clear;
	logic [CNT_W-1:0] fade_step;
	logic             s1_ready;
	rd_req_t          rd_req;
	seq_stat_t        seq_stat;

	// Register block: fade step and the counter wipe that goes with writing it.
	lmfs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.fade_step (fade_step),
		.clear     (clear)
	);

	// Row sequencer: walks the rows of the held tick, one lookup per cycle while the fade stage is ready.
	lmfs_seq #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.scan     (scan),
		.s1_ready (s1_ready),
		.rd_req   (rd_req),
		.stat     (seq_stat)
	);

	// Counter memory, level lookup and the result register feeding drive.
	lmfs_fade #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_fade (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (clear),
		.fade_step (fade_step),
		.rd_req    (rd_req),
		.s1_ready  (s1_ready),
		.drive     (drive)
	);

	// A freshly accepted tick always starts at its first row.
	a_accept_starts_row0: assert property (@(posedge clk) disable iff (!arst_n)
		scan.valid && scan.ready |=> seq_stat.busy && (seq_stat.row == '0))
		else $error("accepted tick did not start at row zero");

	// A tick is only taken while busy when the previous one issues its last row.
	a_accept_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		scan.ready && seq_stat.busy |-> rd_req.valid && rd_req.last)
		else $error("tick accepted before the previous tick finished issuing");

	// The last flag is only seen on the final row of the geometry.
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		drive.valid && drive.last |-> drive.row == ROW_F_W'(ROWS - 1))
		else $error("last flag on a row other than the final one");

endmodule

/* tb/sv/lmfs_fade_checker.sv */
// Watches the scan, drive and APB ports, predicts every drive level and compares.
module lmfs_fade_checker #(
	parameter int COLUMNS = lmfs_pkg::COLUMNS_DEF,
	parameter int ROWS    = lmfs_pkg::ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	lmfs_scan_if                          scan,
	lmfs_drive_if                         drive,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lmfs_pkg::PADDR_W-1:0]  paddr,
	input  logic [lmfs_pkg::PDATA_W-1:0]  pwdata,
	input  logic [lmfs_pkg::PDATA_W-1:0]  prdata,
	input  logic                          pready,
	output int                            fail_count,
	output int                            pending,
	output int                            checked
);
	import lmfs_pkg::*;

	localparam int                 REPORT_MAX = 10;
	localparam logic [CNT_W-1:0]   CNT_FULL   = 6'd63;
	localparam logic [LEVEL_W-1:0] LEVEL_ON   = 8'd255;

	// Perceived brightness for each fade counter value.
	localparam logic [LEVEL_W-1:0] BRIGHTNESS [0:63] = '{
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,
		8'd2,   8'd3,   8'd3,   8'd4,   8'd4,   8'd5,   8'd5,   8'd6,
		8'd6,   8'd7,   8'd8,   8'd9,   8'd10,  8'd11,  8'd12,  8'd13,
		8'd14,  8'd16,  8'd17,  8'd19,  8'd21,  8'd23,  8'd25,  8'd28,
		8'd30,  8'd33,  8'd36,  8'd40,  8'd44,  8'd48,  8'd52,  8'd57,
		8'd62,  8'd68,  8'd74,  8'd81,  8'd89,  8'd97,  8'd106, 8'd115,
		8'd126, 8'd138, 8'd150, 8'd164, 8'd179, 8'd195, 8'd213, 8'd255
	};

	typedef struct packed {
		logic [COL_F_W-1:0] column;
		logic [ROW_F_W-1:0] row;
		logic [LEVEL_W-1:0] level;
		logic               last;
	} drive_level_t;

	drive_level_t     expected_levels [$];
	logic [CNT_W-1:0] fade_cnt [COLUMNS*ROWS];
	logic [CNT_W-1:0] step;
	int               scan_col;
	int               reports;

	// Emits one level per row of the active column, then steps each counter.
	task automatic advance_fades(input logic [TGT_W-1:0] targets);
		logic [CNT_W-1:0] cnt;
		logic [CNT_W:0]   sum;
		logic             on;
		drive_level_t     lvl;
		int               idx;
		for (int r = 0; r < ROWS; r++) begin
			idx = scan_col + r * COLUMNS;
			on  = (r < TGT_W) ? targets[r] : 1'b0;
			cnt = fade_cnt[idx];
			lvl.column = COL_F_W'(scan_col);
			lvl.row    = ROW_F_W'(r);
			lvl.last   = (r == ROWS - 1);
			if (step == '0 && on) begin
				lvl.level = LEVEL_ON;
			end else begin
				lvl.level = BRIGHTNESS[cnt];
				if (on && cnt < CNT_FULL) begin
					sum = {1'b0, cnt} + {1'b0, step};
					cnt = (sum > {1'b0, CNT_FULL}) ? CNT_FULL : sum[CNT_W-1:0];
				end else if (!on && cnt != '0) begin
					cnt = (cnt > step) ? cnt - step : '0;
				end
				fade_cnt[idx] = cnt;
			end
			expected_levels.push_back(lvl);
		end
		scan_col = (scan_col == COLUMNS - 1) ? 0 : scan_col + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		drive_level_t got;
		drive_level_t want;
		int           errs;
		if (!arst_n) begin
			expected_levels.delete();
			foreach (fade_cnt[i]) fade_cnt[i] = '0;
			step       = '0;
			scan_col   = 0;
			reports    = 0;
			fail_count <= 0;
			pending    <= 0;
			checked    <= 0;
		end else begin
			errs = 0;
			if (psel && penable && pready) begin
				if (pwrite && (paddr >> 2) == REG_FADE_STEP) begin
					step = pwdata[CNT_W-1:0];
					foreach (fade_cnt[i]) fade_cnt[i] = '0;
				end else if (!pwrite && (paddr >> 2) == REG_FADE_STEP
						&& prdata !== PDATA_W'(step)) begin
					if (reports < REPORT_MAX)
						$display("%0t fade_step readback: expected %0d, got %0d",
							$time, step, prdata);
					reports++;
					errs++;
				end
			end
			if (scan.valid && scan.ready)
				advance_fades(scan.row_targets);
			if (drive.valid && drive.ready) begin
				got = '{drive.column, drive.row, drive.level, drive.last};
				if (expected_levels.size() == 0) begin
					if (reports < REPORT_MAX)
						$display("%0t unexpected drive level: col %0d row %0d level %0d last %0b",
							$time, got.column, got.row, got.level, got.last);
					reports++;
					errs++;
				end else begin
					want = expected_levels.pop_front();
					if (got !== want) begin
						if (reports < REPORT_MAX)
							$display({"%0t drive mismatch: expected col %0d row %0d level %0d",
								" last %0b, got col %0d row %0d level %0d last %0b"},
								$time, want.column, want.row, want.level, want.last,
								got.column, got.row, got.level, got.last);
						reports++;
						errs++;
					end
				end
				checked <= checked + 1;
			end
			fail_count <= fail_count + errs;
			pending    <= expected_levels.size();
		end
	end

endmodule

/* tb/sv/led_matrix_fade_scanner_top_tb.sv */
// Stimulus, clocking and verdict for the LED matrix fade scanner testbench.
module led_matrix_fade_scanner_top_tb;
	import lmfs_pkg::*;

	localparam int LIMIT     = 300000;
	localparam int DRAIN     = 12;
	localparam int LONG_HOLD = 300;
	localparam int PHASES    = 8;
	localparam int PHASE_LEN = 44;
	localparam int REG_SPARE = 1;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int fail_count;
	int pending;
	int checked;
	int cycle_count = 0;
	int ticks_sent  = 0;

	// Idling switches, shared between the stimulus and the drive-side process.
	bit src_gaps    = 1'b1;
	bit sink_stalls = 1'b1;
	bit hold_req    = 1'b0;

	// Last pattern sent to each column, so that most requests repeat it and the
	// counters have time to travel all the way to either end.
	logic [TGT_W-1:0] col_pattern [COLUMNS_DEF];

	lmfs_scan_if  scan ();
	lmfs_drive_if drive ();

	always #2 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	led_matrix_fade_scanner_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.scan    (scan),
		.drive   (drive),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	lmfs_fade_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.scan       (scan),
		.drive      (drive),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	// Offers one scan request and returns at the edge where it is taken. Before
	// the offer the source may go quiet for a burst; valid is only lowered when
	// such a gap is taken, so it never falls and rises within one time step.
	task automatic offer_scan(input logic [TGT_W-1:0] targets);
		if (src_gaps && $urandom_range(0, 3) == 0) begin
			scan.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		scan.valid       <= 1'b1;
		scan.row_targets <= targets;
		do @(posedge clk); while (!scan.ready);
		ticks_sent++;
	endtask

	// APB transfers: setup cycle, access cycle, then the bus is left idle so that
	// back-to-back transfers never retoggle psel within a time step.
	task automatic apb_write(input int idx, input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(idx * 4);
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read(input int idx);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= PADDR_W'(idx * 4);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// The checker's count of outstanding levels is registered, hence the
	// leading edge before it is polled.
	task automatic wait_drained();
		scan.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// New fade step with random upper data bits, which the register must drop.
	task automatic set_fade_step(input logic [CNT_W-1:0] fade);
		wait_drained();
		apb_write(int'(REG_FADE_STEP), {(PDATA_W - CNT_W)'($urandom()), fade});
		apb_read(int'(REG_FADE_STEP));
	endtask

	// Random targets for the next column: mostly the column's previous pattern,
	// sometimes one flipped row, an all-on or all-off column, or a fresh value.
	function automatic logic [TGT_W-1:0] next_targets(input int c);
		logic [TGT_W-1:0] t;
		case ($urandom_range(0, 9))
			0:       t = TGT_W'($urandom_range(0, 255));
			1:       t = col_pattern[c] ^ (TGT_W'(1) << $urandom_range(0, TGT_W - 1));
			2:       t = $urandom_range(0, 1) ? '1 : '0;
			default: t = col_pattern[c];
		endcase
		col_pattern[c] = t;
		return t;
	endfunction

	// Drive side: ready bursts, random stalls and once a long hold-off during which
	// the scan side keeps offering so the block backs up.
	initial begin
		drive.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				drive.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
				drive.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				drive.ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// Watchdog on the cycle counter.
	initial begin
		while (cycle_count < LIMIT) @(posedge clk);
		$display("[led_matrix_fade_scanner_top] ERROR");
		$finish;
	end

	initial begin
		logic [CNT_W-1:0] fade;
		arst_n           <= 1'b0;
		scan.valid       <= 1'b0;
		scan.row_targets <= '0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= '0;
		foreach (col_pattern[i]) col_pattern[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset the step reads back as zero, and every LED that is on is
		// driven at full brightness while the off ones sit at the bottom of the
		// curve. Eight requests walk through every column once.
		apb_read(int'(REG_FADE_STEP));
		offer_scan(8'hFF);
		offer_scan(8'h00);
		offer_scan(8'hAA);
		offer_scan(8'h55);
		offer_scan(8'h0F);
		offer_scan(8'hF0);
		offer_scan(8'h01);
		offer_scan(8'h80);

		// The largest step takes a counter from one end to the other in a single
		// tick: first everything on, which shows full brightness on the next visit
		// of each column, then everything off and a mixed pattern, which fade out
		// from the top and also leave counters resting at their targets. A write
		// to the unused register slot in between must change nothing.
		set_fade_step(6'd63);
		apb_write(REG_SPARE, $urandom());
		apb_read(int'(REG_FADE_STEP));
		repeat (8) offer_scan(8'hFF);
		repeat (4) offer_scan(8'h00);
		repeat (4) offer_scan(8'h5A);

		// Random phases, each at its own fade step: the slowest, mid-range values,
		// the largest, zero and one random value. The last phase runs with no
		// idling on either side.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0:       fade = 6'd1;
				1:       fade = 6'd4;
				2:       fade = 6'd63;
				3:       fade = 6'd0;
				4:       fade = 6'd2;
				5:       fade = 6'd9;
				6:       fade = 6'd31;
				default: fade = CNT_W'($urandom_range(1, 62));
			endcase
			set_fade_step(fade);
			if (ph == PHASES - 1) begin
				src_gaps    = 1'b0;
				sink_stalls = 1'b0;
			end
			for (int n = 0; n < PHASE_LEN; n++) begin
				if (ph == 2 && n == 5)
					hold_req = 1'b1;
				offer_scan(next_targets(ticks_sent % COLUMNS_DEF));
			end
		end

		wait_drained();
		repeat (DRAIN) @(posedge clk);

		$display("Run covered %0d scan requests over %0d fade step settings and one %0d-cycle",
			ticks_sent, PHASES + 2, LONG_HOLD);
		$display("drive hold-off; %0d drive levels compared, %0d failures.",
			checked, fail_count);
		if (fail_count == 0 && pending == 0) begin
			$display("[led_matrix_fade_scanner_top] OK");
		end else begin
			$display("[led_matrix_fade_scanner_top] ERROR");
		end
		$finish;
	end

endmodule
